// ===== rtl/core/bcd_time_of_day_clock_with_setting_macros.svh =====
// assertion macros for the bcd time-of-day clock checker
// no dependencies; included by the checker file only
`ifndef BCD_TIME_OF_DAY_CLOCK_WITH_SETTING_MACROS_SVH
`define BCD_TIME_OF_DAY_CLOCK_WITH_SETTING_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define BCDC_ASSERT_SAME(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (cond)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define BCDC_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== rtl/core/bcdc_pkg.sv =====
// shared types and constants of the bcd time-of-day clock
// no dependencies; imported by every module of the block
package bcdc_pkg;

    // command codes
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_BUTTON = 2'd1;
    localparam logic [1:0] CMD_ADD    = 2'd2;
    localparam logic [1:0] CMD_SUB    = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_MS_PER_SECOND  = 2'd0;
    localparam logic [1:0] CFG_SYNC_INTERVAL  = 2'd1;
    localparam logic [1:0] CFG_LONG_PRESS     = 2'd2;
    localparam logic [1:0] CFG_SHORT_PRESS    = 2'd3;

    localparam int CFG_DATA_W = 20;

    // configuration reset values
    localparam logic [15:0] MS_PER_SECOND_RST  = 16'd1000;
    localparam logic [19:0] SYNC_INTERVAL_RST  = 20'd900000;
    localparam logic [7:0]  LONG_PRESS_RST     = 8'd100;
    localparam logic [7:0]  SHORT_PRESS_RST    = 8'd5;

    // digit positions
    localparam logic [2:0] POS_HOURS_TENS   = 3'd0;
    localparam logic [2:0] POS_HOURS_UNITS  = 3'd1;
    localparam logic [2:0] POS_MIN_TENS     = 3'd2;
    localparam logic [2:0] POS_MIN_UNITS    = 3'd3;
    localparam logic [2:0] POS_SEC_TENS     = 3'd4;
    localparam logic [2:0] POS_SEC_UNITS    = 3'd5;
    localparam logic [2:0] POS_RESET        = POS_SEC_TENS;

    localparam logic [7:0] HELD_MAX = 8'd255;

    typedef struct packed {
        logic [1:0] command;
        logic       button_level;
    } t_in_item;

    typedef struct packed {
        logic [1:0] hours_tens;
        logic [3:0] hours_units;
        logic [2:0] minutes_tens;
        logic [3:0] minutes_units;
        logic [2:0] seconds_tens;
        logic [3:0] seconds_units;
        logic       setup_active;
        logic [2:0] selected_position;
        logic       sync_request;
    } t_out_item;

    typedef struct packed {
        logic [15:0] ms_per_second;
        logic [19:0] sync_interval_ms;
        logic [7:0]  long_press_samples;
        logic [7:0]  short_press_min;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  hours_tens;
        logic [3:0]  hours_units;
        logic [2:0]  minutes_tens;
        logic [3:0]  minutes_units;
        logic [2:0]  seconds_tens;
        logic [3:0]  seconds_units;
        logic [15:0] tick_count;
        logic [19:0] sync_count;
        logic        in_setup;
        logic [2:0]  edit_position;
        logic [7:0]  held_samples;
        logic        awaiting_release;
    } t_state;

endpackage

// ===== rtl/core/bcdc_cfg_regs.sv =====
// configuration registers of the bcd time-of-day clock
// depends on bcdc_pkg
module bcdc_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [bcdc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output bcdc_pkg::t_cfg                o_cfg
);
    import bcdc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ms_per_second      <= MS_PER_SECOND_RST;
            r_cfg.sync_interval_ms   <= SYNC_INTERVAL_RST;
            r_cfg.long_press_samples <= LONG_PRESS_RST;
            r_cfg.short_press_min    <= SHORT_PRESS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MS_PER_SECOND: r_cfg.ms_per_second      <= i_cfg_data[15:0];
                CFG_SYNC_INTERVAL: r_cfg.sync_interval_ms   <= i_cfg_data[19:0];
                CFG_LONG_PRESS:    r_cfg.long_press_samples <= i_cfg_data[7:0];
                CFG_SHORT_PRESS:   r_cfg.short_press_min    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/bcdc_step.sv =====
// next-state and result logic for one item of the bcd time-of-day clock
// depends on bcdc_pkg; purely combinational
module bcdc_step (
    input  bcdc_pkg::t_state    i_state,
    input  bcdc_pkg::t_cfg      i_cfg,
    input  bcdc_pkg::t_in_item  i_item,
    output bcdc_pkg::t_state    o_next,
    output bcdc_pkg::t_out_item o_result
);
    import bcdc_pkg::*;

    t_state      n_st;
    logic        pulse;
    logic [16:0] tick_inc;
    logic [20:0] sync_inc;
    logic        sec_adv;
    // seconds cascade
    logic        c_su, c_st, c_mu, c_mt;
    logic [3:0]  a_hu;
    logic [2:0]  a_ht;
    logic        hours_wrap;
    // digit edit
    logic [3:0]  cur_digit, lim, new_digit;
    logic [7:0]  held_inc;

    // seconds advance with carries, computed from the current digits
    always_comb begin
        c_su = (i_state.seconds_units >= 4'd9);
        c_st = c_su && (i_state.seconds_tens >= 3'd5);
        c_mu = c_st && (i_state.minutes_units >= 4'd9);
        c_mt = c_mu && (i_state.minutes_tens >= 3'd5);
        a_ht = {1'b0, i_state.hours_tens};
        a_hu = i_state.hours_units;
        if (c_mt) begin
            if (i_state.hours_units >= 4'd9) begin
                a_hu = 4'd0;
                a_ht = {1'b0, i_state.hours_tens} + 3'd1;
            end else begin
                a_hu = i_state.hours_units + 4'd1;
            end
        end
        hours_wrap = c_mt && ((a_ht > 3'd2) || ((a_ht == 3'd2) && (a_hu >= 4'd4)));
    end

    // selected digit and its limit
    always_comb begin
        case (i_state.edit_position)
            POS_HOURS_TENS:  begin cur_digit = {2'b00, i_state.hours_tens};   lim = 4'd2; end
            POS_HOURS_UNITS: begin cur_digit = i_state.hours_units;           lim = 4'd9; end
            POS_MIN_TENS:    begin cur_digit = {1'b0, i_state.minutes_tens};  lim = 4'd5; end
            POS_MIN_UNITS:   begin cur_digit = i_state.minutes_units;         lim = 4'd9; end
            POS_SEC_TENS:    begin cur_digit = {1'b0, i_state.seconds_tens};  lim = 4'd5; end
            POS_SEC_UNITS:   begin cur_digit = i_state.seconds_units;         lim = 4'd9; end
            default:         begin cur_digit = 4'd0;                          lim = 4'd0; end
        endcase
        if (i_item.command == CMD_ADD) begin
            new_digit = (cur_digit >= lim) ? 4'd0 : cur_digit + 4'd1;
        end else begin
            new_digit = (cur_digit == 4'd0) ? lim : cur_digit - 4'd1;
        end
    end

    always_comb begin
        n_st     = i_state;
        pulse    = 1'b0;
        sec_adv  = 1'b0;
        tick_inc = {1'b0, i_state.tick_count} + 17'd1;
        sync_inc = {1'b0, i_state.sync_count} + 21'd1;
        held_inc = (i_state.held_samples < HELD_MAX) ? i_state.held_samples + 8'd1
                                                     : i_state.held_samples;
        case (i_item.command)
            CMD_TICK: begin
                if (!i_state.in_setup) begin
                    if (tick_inc >= {1'b0, i_cfg.ms_per_second}) begin
                        n_st.tick_count = 16'd0;
                        sec_adv         = 1'b1;
                    end else begin
                        n_st.tick_count = tick_inc[15:0];
                    end
                    if (sync_inc >= {1'b0, i_cfg.sync_interval_ms}) begin
                        n_st.sync_count = 20'd0;
                        pulse           = 1'b1;
                    end else begin
                        n_st.sync_count = sync_inc[19:0];
                    end
                end
            end
            CMD_BUTTON: begin
                if (!i_state.in_setup) begin
                    if (i_item.button_level) begin
                        n_st.in_setup         = 1'b1;
                        n_st.edit_position    = POS_RESET;
                        n_st.held_samples     = 8'd0;
                        n_st.awaiting_release = 1'b0;
                        n_st.tick_count       = 16'd0;
                        n_st.sync_count       = 20'd0;
                    end
                end else if (i_state.awaiting_release) begin
                    if (!i_item.button_level) begin
                        n_st.in_setup         = 1'b0;
                        n_st.awaiting_release = 1'b0;
                        n_st.held_samples     = 8'd0;
                    end
                end else if (i_item.button_level) begin
                    n_st.held_samples = held_inc;
                    if (held_inc > i_cfg.long_press_samples) begin
                        n_st.awaiting_release = 1'b1;
                    end
                end else begin
                    // short press steps to the next position
                    if ((i_state.held_samples > i_cfg.short_press_min) &&
                        (i_state.held_samples < i_cfg.long_press_samples)) begin
                        n_st.edit_position = (i_state.edit_position >= POS_SEC_UNITS)
                                           ? POS_HOURS_TENS : i_state.edit_position + 3'd1;
                    end
                    n_st.held_samples = 8'd0;
                end
            end
            default: begin
                if (i_state.in_setup && !i_state.awaiting_release) begin
                    case (i_state.edit_position)
                        POS_HOURS_TENS:  n_st.hours_tens    = new_digit[1:0];
                        POS_HOURS_UNITS: n_st.hours_units   = new_digit;
                        POS_MIN_TENS:    n_st.minutes_tens  = new_digit[2:0];
                        POS_MIN_UNITS:   n_st.minutes_units = new_digit;
                        POS_SEC_TENS:    n_st.seconds_tens  = new_digit[2:0];
                        POS_SEC_UNITS:   n_st.seconds_units = new_digit;
                        default: ;
                    endcase
                end
            end
        endcase

        if (sec_adv) begin
            if (hours_wrap) begin
                n_st.hours_tens    = 2'd0;
                n_st.hours_units   = 4'd0;
                n_st.minutes_tens  = 3'd0;
                n_st.minutes_units = 4'd0;
                n_st.seconds_tens  = 3'd0;
                n_st.seconds_units = 4'd0;
            end else begin
                n_st.seconds_units = c_su ? 4'd0 : i_state.seconds_units + 4'd1;
                if (c_su) begin
                    n_st.seconds_tens = c_st ? 3'd0 : i_state.seconds_tens + 3'd1;
                end
                if (c_st) begin
                    n_st.minutes_units = c_mu ? 4'd0 : i_state.minutes_units + 4'd1;
                end
                if (c_mu) begin
                    n_st.minutes_tens = c_mt ? 3'd0 : i_state.minutes_tens + 3'd1;
                end
                if (c_mt) begin
                    n_st.hours_units = a_hu;
                    n_st.hours_tens  = a_ht[1:0];
                end
            end
        end
    end

    assign o_next = n_st;

    always_comb begin
        o_result.hours_tens        = n_st.hours_tens;
        o_result.hours_units       = n_st.hours_units;
        o_result.minutes_tens      = n_st.minutes_tens;
        o_result.minutes_units     = n_st.minutes_units;
        o_result.seconds_tens      = n_st.seconds_tens;
        o_result.seconds_units     = n_st.seconds_units;
        o_result.setup_active      = n_st.in_setup;
        o_result.selected_position = n_st.edit_position;
        o_result.sync_request      = pulse;
    end

endmodule

// ===== rtl/core/bcd_time_of_day_clock_with_setting.sv =====
// top level of the bcd time-of-day clock with button setting
// depends on bcdc_pkg, bcdc_cfg_regs and bcdc_step
//
// Keeps HH:MM:SS as six bcd digits and answers every item with exactly one
// result item carrying the time after that item, the setup flag, the edited
// position and a resync pulse. Command 0 is a millisecond tick (ignored in
// setup), 1 a set-button sample, 2 and 3 add to or subtract from the edited
// digit. The time wraps to 00:00:00 when a carry takes the hours to 24.
// Items pass an input and a result register, one item per clock unless the
// result side stalls. The whole update of the time, counters and button state
// is one combinational pass in bcdc_step feeding the state register, so
// consecutive items chain with no bubble. The input register keeps taking
// items while a result waits under stall, until both registers are full. The
// user writes configuration registers through the plain write port only while
// the block is idle, which it does not enforce; reset restores their defaults.
module bcd_time_of_day_clock_with_setting (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  bcdc_pkg::t_in_item              i_in_item,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output bcdc_pkg::t_out_item             o_out_item,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_index,
    input  logic [bcdc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bcdc_pkg::*;

    t_cfg      cfg;
    t_state    r_state;
    t_state    n_state;
    t_out_item n_result;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      out_load;   // result register can take a new item
    logic      advance;    // held item moves through the update
    logic      in_take;    // input register takes a new item

    bcdc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bcdc_step u_step (
        .i_state  (r_state),
        .i_cfg    (cfg),
        .i_item   (r_in_item),
        .o_next   (n_state),
        .o_result (n_result)
    );

    assign out_load   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_load;
    assign in_take    = i_in_valid && !o_in_stall;
    // input side stalls only when the held item cannot move on
    assign o_in_stall = r_in_valid && !out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{hours_tens: 2'd0, hours_units: 4'd0,
                            minutes_tens: 3'd0, minutes_units: 4'd0,
                            seconds_tens: 3'd0, seconds_units: 4'd0,
                            tick_count: 16'd0, sync_count: 20'd0,
                            in_setup: 1'b0, edit_position: POS_RESET,
                            held_samples: 8'd0, awaiting_release: 1'b0};
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
            // state commits together with the result of the item
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/core/bcdc_checker.sv =====
// port-level checks for the bcd time-of-day clock, bound to the top level
// depends on bcdc_pkg and the assertion macro header
`include "bcd_time_of_day_clock_with_setting_macros.svh"

module bcdc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_stall,
    input bcdc_pkg::t_out_item i_out_item
);
    import bcdc_pkg::*;

    `BCDC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        i_out_valid && i_out_stall, i_out_valid && $stable(i_out_item),
        "stalled result item changed")
    `BCDC_ASSERT_SAME(a_sync_in_run, i_clk, i_rst_n,
        i_out_valid && i_out_item.sync_request, !i_out_item.setup_active,
        "resync pulse while in setup")
    `BCDC_ASSERT_SAME(a_pos_range, i_clk, i_rst_n,
        i_out_valid, i_out_item.selected_position <= POS_SEC_UNITS,
        "edit position out of range")
    `BCDC_ASSERT_SAME(a_tens_range, i_clk, i_rst_n,
        i_out_valid,
        (i_out_item.hours_tens <= 2'd2) && (i_out_item.minutes_tens <= 3'd5) &&
            (i_out_item.seconds_tens <= 3'd5),
        "tens digit beyond its limit")

endmodule

bind bcd_time_of_day_clock_with_setting bcdc_checker u_bcdc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_item  (o_out_item)
);

// ===== verif/bcdc_result_checker.sv =====
// result checker for the bcd time-of-day clock: predicts each result item and compares it
// depends on bcdc_pkg; watches the item channels and the configuration write port
`timescale 1ns / 100ps

module bcdc_result_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  bcdc_pkg::t_in_item              i_in_item,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  bcdc_pkg::t_out_item             i_out_item,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_index,
    input  logic [bcdc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import bcdc_pkg::*;

    localparam int unsigned DIGITS = 6;

    // shadow configuration
    logic [15:0] cfg_ms;
    logic [19:0] cfg_sync;
    logic [7:0]  cfg_long;
    logic [7:0]  cfg_short;

    // shadow clock state
    logic [3:0]  clk_digit [DIGITS];
    int unsigned ms_count;
    int unsigned resync_count;
    logic        setup_mode;
    logic [2:0]  edit_pos;
    int unsigned press_len;
    logic        wait_release;

    t_out_item   expected_displays [$];
    int          fails = 0;

    assign o_fail_count = fails;

    // runs one command against the shadow state, returns the display it should produce
    function automatic t_out_item apply_command(input t_in_item it);
        t_out_item  r;
        logic       pulse;
        logic [2:0] p;
        logic [3:0] top_val;
        pulse = 1'b0;
        case (it.command)
            CMD_TICK: begin
                if (!setup_mode) begin
                    ms_count++;
                    if (ms_count >= cfg_ms) begin
                        ms_count = 0;
                        // ripple carry from seconds units up to hours
                        clk_digit[5]++;
                        if (clk_digit[5] >= 10) begin
                            clk_digit[5] = 0;
                            clk_digit[4]++;
                            if (clk_digit[4] >= 6) begin
                                clk_digit[4] = 0;
                                clk_digit[3]++;
                                if (clk_digit[3] >= 10) begin
                                    clk_digit[3] = 0;
                                    clk_digit[2]++;
                                    if (clk_digit[2] >= 6) begin
                                        clk_digit[2] = 0;
                                        clk_digit[1]++;
                                        if (clk_digit[1] >= 10) begin
                                            clk_digit[1] = 0;
                                            clk_digit[0]++;
                                        end
                                        if (clk_digit[0] * 10 + clk_digit[1] >= 24) begin
                                            for (int i = 0; i < DIGITS; i++) clk_digit[i] = 0;
                                        end
                                    end
                                end
                            end
                        end
                    end
                    resync_count++;
                    if (resync_count >= cfg_sync) begin
                        resync_count = 0;
                        pulse = 1'b1;
                    end
                end
            end
            CMD_BUTTON: begin
                if (!setup_mode) begin
                    if (it.button_level) begin
                        setup_mode   = 1'b1;
                        edit_pos     = POS_RESET;
                        press_len    = 0;
                        wait_release = 1'b0;
                        ms_count     = 0;
                        resync_count = 0;
                    end
                end else if (wait_release) begin
                    if (!it.button_level) begin
                        setup_mode   = 1'b0;
                        wait_release = 1'b0;
                        press_len    = 0;
                    end
                end else if (it.button_level) begin
                    if (press_len < HELD_MAX) press_len++;
                    if (press_len > cfg_long) wait_release = 1'b1;
                end else begin
                    if (press_len > cfg_short && press_len < cfg_long)
                        edit_pos = 3'((edit_pos + 1) % DIGITS);
                    press_len = 0;
                end
            end
            default: begin
                if (setup_mode && !wait_release) begin
                    p = 3'(edit_pos % DIGITS);
                    case (p)
                        POS_HOURS_TENS:             top_val = 4'd2;
                        POS_MIN_TENS, POS_SEC_TENS: top_val = 4'd5;
                        default:                    top_val = 4'd9;
                    endcase
                    if (it.command == CMD_ADD)
                        clk_digit[p] = (clk_digit[p] >= top_val) ? 4'd0 : clk_digit[p] + 4'd1;
                    else
                        clk_digit[p] = (clk_digit[p] == 0) ? top_val : clk_digit[p] - 4'd1;
                end
            end
        endcase
        r                   = '0;
        r.hours_tens        = clk_digit[0][1:0];
        r.hours_units       = clk_digit[1];
        r.minutes_tens      = clk_digit[2][2:0];
        r.minutes_units     = clk_digit[3];
        r.seconds_tens      = clk_digit[4][2:0];
        r.seconds_units     = clk_digit[5];
        r.setup_active      = setup_mode;
        r.selected_position = edit_pos;
        r.sync_request      = pulse;
        return r;
    endfunction

    task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] seen);
        fails++;
        $display("%0t: %s expected %0d got %0d", $time, name, want, seen);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            cfg_ms       = MS_PER_SECOND_RST;
            cfg_sync     = SYNC_INTERVAL_RST;
            cfg_long     = LONG_PRESS_RST;
            cfg_short    = SHORT_PRESS_RST;
            for (int i = 0; i < DIGITS; i++) clk_digit[i] = 0;
            ms_count     = 0;
            resync_count = 0;
            setup_mode   = 1'b0;
            edit_pos     = POS_RESET;
            press_len    = 0;
            wait_release = 1'b0;
            expected_displays.delete();
            o_pending <= 0;
        end else begin
            // results leave before the item taken at this edge can have produced one
            if (i_out_valid && !i_out_stall) begin
                if (expected_displays.size() == 0) begin
                    fails++;
                    $display("%0t: result item with none expected, got %p", $time, i_out_item);
                end else begin
                    want = expected_displays.pop_front();
                    if (want.hours_tens !== i_out_item.hours_tens)
                        flag_field("hours_tens", want.hours_tens, i_out_item.hours_tens);
                    if (want.hours_units !== i_out_item.hours_units)
                        flag_field("hours_units", want.hours_units, i_out_item.hours_units);
                    if (want.minutes_tens !== i_out_item.minutes_tens)
                        flag_field("minutes_tens", want.minutes_tens, i_out_item.minutes_tens);
                    if (want.minutes_units !== i_out_item.minutes_units)
                        flag_field("minutes_units", want.minutes_units, i_out_item.minutes_units);
                    if (want.seconds_tens !== i_out_item.seconds_tens)
                        flag_field("seconds_tens", want.seconds_tens, i_out_item.seconds_tens);
                    if (want.seconds_units !== i_out_item.seconds_units)
                        flag_field("seconds_units", want.seconds_units, i_out_item.seconds_units);
                    if (want.setup_active !== i_out_item.setup_active)
                        flag_field("setup_active", want.setup_active, i_out_item.setup_active);
                    if (want.selected_position !== i_out_item.selected_position)
                        flag_field("selected_position", want.selected_position,
                                   i_out_item.selected_position);
                    if (want.sync_request !== i_out_item.sync_request)
                        flag_field("sync_request", want.sync_request, i_out_item.sync_request);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MS_PER_SECOND: cfg_ms    = i_cfg_data[15:0];
                    CFG_SYNC_INTERVAL: cfg_sync  = i_cfg_data[19:0];
                    CFG_LONG_PRESS:    cfg_long  = i_cfg_data[7:0];
                    CFG_SHORT_PRESS:   cfg_short = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                expected_displays.push_back(apply_command(i_in_item));
            o_pending <= expected_displays.size();
        end
    end

endmodule

// ===== verif/tb_bcd_time_of_day_clock_with_setting.sv =====
// testbench top for the bcd time-of-day clock: reset, configuration phases and item stimulus
// depends on bcdc_pkg, the block and bcdc_result_checker, which predicts and compares
`timescale 1ns / 100ps

module tb_bcd_time_of_day_clock_with_setting;
    import bcdc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 64;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  cfg_we    = 1'b0;
    logic [1:0]            cfg_index = CFG_MS_PER_SECOND;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int        fail_count;
    int        pending;
    int        cycle_count = 0;
    int        items_sent  = 0;
    logic      gaps_on     = 1'b1;
    t_out_item last_result = '0;

    // press thresholds currently loaded, needed to shape button sequences
    int unsigned cur_long;
    int unsigned cur_short;

    // per-phase settings: ms per second, resync interval, long press, short press
    int unsigned phase_ms    [PHASES] = '{1, 65535, 3, 1, 2, 1, 5};
    int unsigned phase_sync  [PHASES] = '{1, 1048575, 7, 13, 50, 1048575, 3};
    int unsigned phase_long  [PHASES] = '{255, 1, 6, 4, 8, 20, 30};
    int unsigned phase_short [PHASES] = '{255, 0, 1, 1, 2, 5, 5};
    // time preset before a phase's random items, hhmmss; zero means none
    int unsigned phase_clock [PHASES] = '{0, 0, 235955, 295957, 195958, 95959, 0};

    bcd_time_of_day_clock_with_setting dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bcdc_result_checker clock_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side stalls at random while gaps are enabled
    always @(posedge clk) begin
        out_stall <= gaps_on && ($urandom_range(99) < 23);
    end

    // latest accepted display, used to steer the time-setting sequences
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) last_result <= out_item;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bcd_time_of_day_clock_with_setting test failed");
            $finish;
        end
    end

    // offer one item, with random idle cycles ahead of it, and wait until it is taken
    task automatic send_item(input logic [1:0] cmd, input logic level);
        while (gaps_on && $urandom_range(99) < 23) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid             <= 1'b1;
        in_item.command      <= cmd;
        in_item.button_level <= level;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    // stop offering items and wait until every predicted display has come back
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // write all four registers on consecutive cycles; the block must be idle
    task automatic load_settings(input int unsigned ms, input int unsigned sync,
                                 input int unsigned press_long, input int unsigned press_short);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MS_PER_SECOND;
        cfg_data  <= CFG_DATA_W'(ms);
        @(posedge clk);
        cfg_index <= CFG_SYNC_INTERVAL;
        cfg_data  <= CFG_DATA_W'(sync);
        @(posedge clk);
        cfg_index <= CFG_LONG_PRESS;
        cfg_data  <= CFG_DATA_W'(press_long);
        @(posedge clk);
        cfg_index <= CFG_SHORT_PRESS;
        cfg_data  <= CFG_DATA_W'(press_short);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_long  = press_long;
        cur_short = press_short;
    endtask

    task automatic tick_run(input int n);
        repeat (n) send_item(CMD_TICK, 1'($urandom_range(1)));
    endtask

    // one press and release that is long enough to leave setup
    task automatic long_press();
        repeat (cur_long + 1) send_item(CMD_BUTTON, 1'b1);
        send_item(CMD_BUTTON, 1'b0);
    endtask

    // walk the setup menu to a given time, reading back each digit to know how far to step;
    // needs short_press_min + 1 < long_press_samples
    task automatic set_clock(input int unsigned hhmmss);
        int unsigned want [6];
        int unsigned have;
        int unsigned span;
        int unsigned steps;
        want[0] = hhmmss / 100000;
        want[1] = (hhmmss / 10000) % 10;
        want[2] = (hhmmss / 1000) % 10;
        want[3] = (hhmmss / 100) % 10;
        want[4] = (hhmmss / 10) % 10;
        want[5] = hhmmss % 10;
        settle();
        // a release either leaves setup or leaves it with no press counted
        if (last_result.setup_active) begin
            send_item(CMD_BUTTON, 1'b0);
            settle();
        end
        if (!last_result.setup_active) begin
            send_item(CMD_BUTTON, 1'b1);
            settle();
        end
        for (int p = 0; p < 6; p++) begin
            steps = (p + 6 - last_result.selected_position) % 6;
            repeat (steps) begin
                repeat (cur_short + 1) send_item(CMD_BUTTON, 1'b1);
                send_item(CMD_BUTTON, 1'b0);
            end
            settle();
            case (p)
                POS_HOURS_TENS:  begin have = last_result.hours_tens;    span = 3;  end
                POS_HOURS_UNITS: begin have = last_result.hours_units;   span = 10; end
                POS_MIN_TENS:    begin have = last_result.minutes_tens;  span = 6;  end
                POS_MIN_UNITS:   begin have = last_result.minutes_units; span = 10; end
                POS_SEC_TENS:    begin have = last_result.seconds_tens;  span = 6;  end
                default:         begin have = last_result.seconds_units; span = 10; end
            endcase
            repeat ((want[p] + span - have) % span)
                send_item(CMD_ADD, 1'($urandom_range(1)));
        end
        long_press();
    endtask

    // enter setup, mix presses of random length with digit steps, usually leave again
    task automatic setup_session();
        int rounds;
        int presses;
        send_item(CMD_BUTTON, 1'b1);
        rounds = $urandom_range(1, 4);
        repeat (rounds) begin
            if ($urandom_range(1)) begin
                presses = $urandom_range(0, (cur_long + 2 < 24) ? cur_long + 2 : 24);
                repeat (presses) send_item(CMD_BUTTON, 1'b1);
                send_item(CMD_BUTTON, 1'b0);
            end
            repeat ($urandom_range(0, 12))
                send_item($urandom_range(1) ? CMD_ADD : CMD_SUB, 1'($urandom_range(1)));
            // ticks in setup must be ignored
            if ($urandom_range(9) == 0) send_item(CMD_TICK, 1'b0);
        end
        if (cur_long < 64) begin
            repeat (cur_long + 1) send_item(CMD_BUTTON, 1'b1);
            // steps while waiting for the release are ignored
            if ($urandom_range(1)) send_item(CMD_ADD, 1'b1);
            send_item(CMD_BUTTON, 1'b0);
        end
    endtask

    initial begin
        // opening sequence, run with ms_per_second 1, resync every 2 ticks,
        // long press above 3 samples, short press above 0
        t_in_item opening_items [26] = '{
            '{CMD_TICK,   1'b1},  // one second
            '{CMD_TICK,   1'b0},  // another second plus resync pulse
            '{CMD_SUB,    1'b0},  // steps outside setup are ignored
            '{CMD_BUTTON, 1'b0},  // release in run mode does nothing
            '{CMD_BUTTON, 1'b1},  // enter setup on seconds tens
            '{CMD_TICK,   1'b0},  // tick in setup is ignored
            '{CMD_BUTTON, 1'b1},
            '{CMD_BUTTON, 1'b0},  // short press moves to seconds units
            '{CMD_SUB,    1'b0},
            '{CMD_SUB,    1'b1},
            '{CMD_SUB,    1'b0},  // subtract from zero wraps to nine
            '{CMD_ADD,    1'b0},  // add from nine wraps to zero
            '{CMD_BUTTON, 1'b1},
            '{CMD_BUTTON, 1'b1},
            '{CMD_BUTTON, 1'b0},  // short press wraps the position to hours tens
            '{CMD_ADD,    1'b1},
            '{CMD_ADD,    1'b0},
            '{CMD_ADD,    1'b1},  // hours tens wraps from two to zero
            '{CMD_SUB,    1'b1},  // and back to two
            '{CMD_BUTTON, 1'b1},
            '{CMD_BUTTON, 1'b1},
            '{CMD_BUTTON, 1'b1},
            '{CMD_BUTTON, 1'b1},  // past the long press limit, now waiting for release
            '{CMD_ADD,    1'b0},  // ignored while waiting for release
            '{CMD_BUTTON, 1'b0},  // release leaves setup
            '{CMD_TICK,   1'b1}
        };
        int goal;
        int pick;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_settings(1, 2, 3, 0);
        foreach (opening_items[i])
            send_item(opening_items[i].command, opening_items[i].button_level);

        for (int ph = 0; ph < PHASES; ph++) begin
            // every item answers with one result, so a drained checker means an idle block
            settle();
            load_settings(phase_ms[ph], phase_sync[ph], phase_long[ph], phase_short[ph]);
            // one phase runs with no idling on either side
            gaps_on <= (ph != 4);
            if (phase_clock[ph] != 0) begin
                set_clock(phase_clock[ph]);
                // enough ticks to push the preset time over the next hour carry
                tick_run(10 * phase_ms[ph] + 2);
            end
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) begin
                pick = $urandom_range(99);
                if (pick < 35)
                    tick_run($urandom_range(1, 20));
                else if (pick < 80)
                    setup_session();
                else
                    repeat ($urandom_range(1, 8))
                        send_item(2'($urandom_range(3)), 1'($urandom_range(1)));
            end
            // leave the counters part way, so the next settings may start below them
            tick_run($urandom_range(5, 30));
        end

        settle();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("bcd_time_of_day_clock_with_setting test passed");
        else
            $display("bcd_time_of_day_clock_with_setting test failed");
        $finish;
    end

endmodule
